### hw/rtl/qoa_pkg.sv
// Package for the quaternion orientation accumulator.
// Holds widths, command codes, the product schedule and the control and status types.
// Depends on nothing.
package qoa_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W = 66;
   localparam int MAG_W = 65;
   localparam int V_W = 31;
   localparam int SUM_W = 64;
   localparam int OP_W = 33;
   localparam int PROD_W = 66;
   localparam int ROOT_W = 33;
   localparam int FRAC_BITS_DEF = 28;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MUL = 1'b1;

   typedef struct packed {
      logic [1:0] psel;
      logic [1:0] qsel;
      logic       neg;
   } mul_plan_type;

   typedef struct packed {
      logic       take;
      logic       mul_step;
      logic       abs_step;
      logic       scale_step;
      logic       sq_step;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       round_step;
      logic       div_init;
      logic       div_step;
      logic       div_end;
      logic       commit;
      logic [3:0] idx;
   } ctrl_type;

   typedef struct packed {
      logic is_mul;
      logic zero;
      logic scaled;
   } sts_type;

   // Product schedule of the Hamilton product, four terms per output component.
   function automatic mul_plan_type mul_plan(input logic [3:0] idx);
      mul_plan_type p;
      case (idx)
         4'd0:    p = '{psel: 2'd0, qsel: 2'd0, neg: 1'b0};
         4'd1:    p = '{psel: 2'd1, qsel: 2'd1, neg: 1'b1};
         4'd2:    p = '{psel: 2'd2, qsel: 2'd2, neg: 1'b1};
         4'd3:    p = '{psel: 2'd3, qsel: 2'd3, neg: 1'b1};
         4'd4:    p = '{psel: 2'd0, qsel: 2'd1, neg: 1'b0};
         4'd5:    p = '{psel: 2'd1, qsel: 2'd0, neg: 1'b0};
         4'd6:    p = '{psel: 2'd2, qsel: 2'd3, neg: 1'b0};
         4'd7:    p = '{psel: 2'd3, qsel: 2'd2, neg: 1'b1};
         4'd8:    p = '{psel: 2'd0, qsel: 2'd2, neg: 1'b0};
         4'd9:    p = '{psel: 2'd2, qsel: 2'd0, neg: 1'b0};
         4'd10:   p = '{psel: 2'd3, qsel: 2'd1, neg: 1'b0};
         4'd11:   p = '{psel: 2'd1, qsel: 2'd3, neg: 1'b1};
         4'd12:   p = '{psel: 2'd0, qsel: 2'd3, neg: 1'b0};
         4'd13:   p = '{psel: 2'd3, qsel: 2'd0, neg: 1'b0};
         4'd14:   p = '{psel: 2'd1, qsel: 2'd2, neg: 1'b0};
         default: p = '{psel: 2'd2, qsel: 2'd1, neg: 1'b1};
      endcase
      return p;
   endfunction

endpackage

### hw/rtl/qoa_datapath.sv
// Datapath of the quaternion orientation accumulator.
// Shared multiplier, accumulators, block scaling, square root and divider.
// Depends on qoa_pkg.
module qoa_datapath #(
   parameter int FRAC_BITS = qoa_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qoa_pkg::ctrl_type            ctrl,
   output qoa_pkg::sts_type             sts,
   input  logic                         req_cmd,
   input  logic [4*qoa_pkg::DATA_W-1:0] req_data,
   output logic [4*qoa_pkg::DATA_W-1:0] rsp_data,
   output logic                         rsp_flag
);
   import qoa_pkg::*;

   localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0] BIT_TOP = SUM_W'(1) << (SUM_W - 2);

   logic [DATA_W-1:0] p_ff [4], p_in [4];
   logic [DATA_W-1:0] q_ff [4], q_in [4];
   logic [DATA_W-1:0] res_ff [4], res_in [4];
   logic [DATA_W-1:0] out_ff [4], out_in [4];
   logic              flag_ff, flag_in;
   logic              cmd_ff, cmd_in;
   logic signed [ACC_W-1:0] acc_ff [4], acc_in [4];
   logic [MAG_W-1:0]  mag_ff [4], mag_in [4];
   logic              neg_ff [4], neg_in [4];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic              pend_acc_ff, pend_acc_in, pend_sq_ff, pend_sq_in, pend_neg_ff, pend_neg_in;
   logic [1:0]        pend_idx_ff, pend_idx_in;
   logic [SUM_W-1:0]  sum_ff, sum_in, rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [ROOT_W-1:0] dr_ff, dr_in;
   logic [DATA_W-1:0] dq_ff, dq_in;

   mul_plan_type plan;
   logic signed [OP_W-1:0] op_a, op_b;
   logic [MAG_W-1:0] or_all;
   logic [V_W-1:0] v [4];
   logic [SUM_W-1:0] trial, num;
   logic [ROOT_W-1:0] m;
   logic [ROOT_W:0] t;
   logic ge;

   assign plan = mul_plan(ctrl.idx);
   assign or_all = mag_ff[0] | mag_ff[1] | mag_ff[2] | mag_ff[3];
   assign m = root_ff[ROOT_W-1:0];
   assign trial = rem_ff - (root_ff + bit_ff);
   assign num = (SUM_W'(v[ctrl.idx[1:0]]) << FRAC_BITS) + SUM_W'(m >> 1);
   assign t = {dr_ff, dq_ff[DATA_W-1]};
   assign ge = t >= {1'b0, m};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         v[i] = mag_ff[i][V_W-1:0];
      end
      if (ctrl.sq_step) begin
         op_a = OP_W'(v[ctrl.idx[1:0]]);
         op_b = OP_W'(v[ctrl.idx[1:0]]);
      end else begin
         op_a = {p_ff[plan.psel][DATA_W-1], p_ff[plan.psel]};
         op_b = {q_ff[plan.qsel][DATA_W-1], q_ff[plan.qsel]};
      end
   end

   always_comb begin
      prod_in = op_a * op_b;
      pend_acc_in = ctrl.mul_step;
      pend_sq_in = ctrl.sq_step;
      pend_neg_in = plan.neg;
      pend_idx_in = ctrl.idx[3:2];
      cmd_in = ctrl.take ? req_cmd : cmd_ff;
      for (int i = 0; i < 4; i++) begin
         q_in[i] = ctrl.take ? req_data[i*DATA_W +: DATA_W] : q_ff[i];
         acc_in[i] = acc_ff[i];
         if (ctrl.take) begin
            if (req_cmd == CMD_LOAD) begin
               acc_in[i] = ACC_W'($signed(req_data[i*DATA_W +: DATA_W]));
            end else begin
               acc_in[i] = '0;
            end
         end else if (pend_acc_ff && pend_idx_ff == 2'(i)) begin
            acc_in[i] = pend_neg_ff ? acc_ff[i] - prod_ff : acc_ff[i] + prod_ff;
         end
         mag_in[i] = mag_ff[i];
         neg_in[i] = neg_ff[i];
         if (ctrl.abs_step) begin
            neg_in[i] = acc_ff[i][ACC_W-1];
            mag_in[i] = acc_ff[i][ACC_W-1] ? MAG_W'(-acc_ff[i]) : MAG_W'(acc_ff[i]);
         end else if (ctrl.scale_step) begin
            if (|or_all[MAG_W-1:V_W+8]) begin
               mag_in[i] = mag_ff[i] >> 8;
            end else if (|or_all[MAG_W-1:V_W]) begin
               mag_in[i] = mag_ff[i] >> 1;
            end else if (or_all[V_W-2:V_W-9] == '0) begin
               mag_in[i] = mag_ff[i] << 8;
            end else begin
               mag_in[i] = mag_ff[i] << 1;
            end
         end
         res_in[i] = res_ff[i];
         if (ctrl.div_end && ctrl.idx[1:0] == 2'(i)) begin
            if (neg_ff[i]) begin
               res_in[i] = (dq_ff > {1'b1, {(DATA_W-1){1'b0}}}) ?
                  {1'b1, {(DATA_W-1){1'b0}}} : -dq_ff;
            end else begin
               res_in[i] = dq_ff[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : dq_ff;
            end
         end
         p_in[i] = p_ff[i];
         out_in[i] = out_ff[i];
         if (ctrl.commit) begin
            if (sts.zero) begin
               out_in[i] = p_ff[i];
            end else begin
               p_in[i] = res_ff[i];
               out_in[i] = res_ff[i];
            end
         end
      end
      flag_in = ctrl.commit ? sts.zero : flag_ff;

      sum_in = sum_ff;
      if (ctrl.abs_step) begin
         sum_in = '0;
      end else if (pend_sq_ff) begin
         sum_in = sum_ff + prod_ff[SUM_W-1:0];
      end

      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      if (ctrl.sqrt_init) begin
         rem_in = sum_ff;
         root_in = '0;
         bit_in = BIT_TOP;
      end else if (ctrl.sqrt_step) begin
         bit_in = bit_ff >> 2;
         if (rem_ff >= root_ff + bit_ff) begin
            rem_in = trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
      end else if (ctrl.round_step) begin
         if (rem_ff > root_ff) begin
            root_in = root_ff + SUM_W'(1);
         end
      end

      dr_in = dr_ff;
      dq_in = dq_ff;
      if (ctrl.div_init) begin
         dr_in = ROOT_W'(num[SUM_W-1:DATA_W]);
         dq_in = num[DATA_W-1:0];
      end else if (ctrl.div_step) begin
         dr_in = ge ? ROOT_W'(t - {1'b0, m}) : t[ROOT_W-1:0];
         dq_in = {dq_ff[DATA_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff[0] <= ONE;
         p_ff[1] <= '0;
         p_ff[2] <= '0;
         p_ff[3] <= '0;
         pend_acc_ff <= 1'b0;
         pend_sq_ff <= 1'b0;
      end else begin
         p_ff <= p_in;
         pend_acc_ff <= pend_acc_in;
         pend_sq_ff <= pend_sq_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      res_ff <= res_in;
      out_ff <= out_in;
      flag_ff <= flag_in;
      cmd_ff <= cmd_in;
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      pend_neg_ff <= pend_neg_in;
      pend_idx_ff <= pend_idx_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      dr_ff <= dr_in;
      dq_ff <= dq_in;
   end

   assign sts.is_mul = (cmd_ff == CMD_MUL);
   assign sts.zero = (or_all == '0);
   assign sts.scaled = (or_all[MAG_W-1:V_W] == '0) && or_all[V_W-1];
   assign rsp_data = {out_ff[3], out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_flag = flag_ff;

endmodule

### hw/rtl/qoa_controller.sv
// Controller of the quaternion orientation accumulator.
// Sequences products, scaling, square root and divisions; owns the handshakes.
// Depends on qoa_pkg.
module qoa_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  qoa_pkg::sts_type  sts,
   output qoa_pkg::ctrl_type ctrl
);
   import qoa_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_MUL       = 4'd2;
   localparam logic [3:0] S_ABS       = 4'd3;
   localparam logic [3:0] S_SCALE     = 4'd4;
   localparam logic [3:0] S_SQ        = 4'd5;
   localparam logic [3:0] S_SQRT_INIT = 4'd6;
   localparam logic [3:0] S_SQRT      = 4'd7;
   localparam logic [3:0] S_ROUND     = 4'd8;
   localparam logic [3:0] S_DIV_INIT  = 4'd9;
   localparam logic [3:0] S_DIV       = 4'd10;
   localparam logic [3:0] S_DIV_END   = 4'd11;
   localparam logic [3:0] S_DONE      = 4'd12;

   localparam logic [5:0] MUL_N = 6'd16;
   localparam logic [5:0] SQ_N = 6'd4;
   localparam logic [5:0] ITER_LAST = 6'(DATA_W - 1);

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] didx_ff, didx_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      didx_in = didx_ff;
      ctrl = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.take = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cnt_in = '0;
            state_in = sts.is_mul ? S_MUL : S_ABS;
         end
         S_MUL: begin
            ctrl.idx = cnt_ff[3:0];
            if (cnt_ff == MUL_N) begin
               state_in = S_ABS;
            end else begin
               ctrl.mul_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_ABS: begin
            ctrl.abs_step = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cnt_in = '0;
            if (sts.zero) begin
               state_in = S_DONE;
            end else if (sts.scaled) begin
               state_in = S_SQ;
            end else begin
               ctrl.scale_step = 1'b1;
            end
         end
         S_SQ: begin
            ctrl.idx = cnt_ff[3:0];
            if (cnt_ff == SQ_N) begin
               state_in = S_SQRT_INIT;
            end else begin
               ctrl.sq_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_SQRT_INIT: begin
            ctrl.sqrt_init = 1'b1;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            ctrl.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == ITER_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            ctrl.round_step = 1'b1;
            didx_in = '0;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            ctrl.div_init = 1'b1;
            ctrl.idx = {2'b00, didx_ff};
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == ITER_LAST) begin
               state_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            ctrl.div_end = 1'b1;
            ctrl.idx = {2'b00, didx_ff};
            didx_in = didx_ff + 2'd1;
            state_in = (didx_ff == 2'd3) ? S_DONE : S_DIV_INIT;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         didx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         didx_ff <= didx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/quaternion_orientation_accumulator.sv
// Quaternion orientation accumulator, top level.
// Keeps a Q3.28 orientation; a load item sets it, a multiply item multiplies
// it by the item, and each new value is normalized and sent as one result item.
// The req channel carries the command in tuser and the quaternion in tdata.
// The rsp channel carries the new orientation in tdata and the zero flag in tuser.
// A multiply item's result comes later than a load item's by its sixteen products, and
// the time to a result varies with the number of block-scaling shifts.
// Sixteen products and four squares go through one shared multiplier, the root
// takes one result bit a cycle, and four divisions follow, one per component.
// An item whose magnitude is zero skips the squares, the root and the divisions.
// Only one item is in work at a time; req_tready is high while the block is idle,
// so a new item is taken the cycle after a result is committed.
// A result waits in the output register while the receiver stalls, and the next
// item is accepted meanwhile, but its result is held back until the slot is free.
// Synchronous reset returns the orientation to identity and empties the output.
// Depends on qoa_pkg, qoa_controller and qoa_datapath.
module quaternion_orientation_accumulator #(
   parameter int FRAC_BITS = qoa_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [4*qoa_pkg::DATA_W-1:0] req_tdata,  // in_w, in_x, in_y, in_z
   input  logic                         req_tuser,  // cmd
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [4*qoa_pkg::DATA_W-1:0] rsp_tdata,  // out_w, out_x, out_y, out_z
   output logic                         rsp_tuser   // zero_norm
);
   import qoa_pkg::*;

   ctrl_type ctrl;
   sts_type  sts;

   qoa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .ctrl      (ctrl)
   );

   qoa_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .sts      (sts),
      .req_cmd  (req_tuser),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata),
      .rsp_flag (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a waiting result");
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_tvalid)
      else $error("finished result not presented");
`endif

endmodule
